// File: design/diffusion_stencil_3x3_step_core_defines.svh
// Assertion macros shared by the diffusion stencil core RTL files.
// Defining NO_ASSERTIONS turns every check into an empty statement.
`ifndef DIFFUSION_STENCIL_3X3_STEP_CORE_DEFINES_SVH
`define DIFFUSION_STENCIL_3X3_STEP_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DSTS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dsts assertion failed");
`define DSTS_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dsts forbidden condition seen");
`else
`define DSTS_ASSERT(label, clk, rst_n, prop)
`define DSTS_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: design/dsts_pkg.sv
// Package of the diffusion stencil core: widths, register codes and the
// word types passed between the front end, the queue and the back end.
// No dependencies.
package dsts_pkg;

    localparam int DATA_W     = 32;
    localparam int COORD_W    = 10;
    localparam int LAYER_W    = 8;
    localparam int COEF_W     = 24;
    localparam int CFG_SIZE_W = 11;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    localparam int Q_DEPTH = 4;
    localparam int QPW     = $clog2(Q_DEPTH);
    localparam int QCW     = $clog2(Q_DEPTH + 1);

    localparam int SUM4_W  = 34;
    localparam int S_W     = 37;
    localparam int S_LO_W  = 18;
    localparam int PLO_W   = COEF_W + S_LO_W;
    localparam int PHI_W   = COEF_W + 1 + S_W - S_LO_W;
    localparam int PDEG_W  = COEF_W + 1 + DATA_W;
    localparam int T_W     = 62;
    localparam int CH_W    = 45;
    localparam int CH_LO_W = 22;
    localparam int QLO_W   = COEF_W + CH_LO_W;
    localparam int QHI_W   = COEF_W + 1 + CH_W - CH_LO_W;
    localparam int P_W     = 70;
    localparam int RND_W   = 54;
    localparam int SUM_W   = 55;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    localparam logic [CFG_SIZE_W-1:0] SIZE_RST = 11'd64;

    typedef enum logic [2:0] {
        REG_DIFF   = 3'd0,
        REG_DEG    = 3'd1,
        REG_DT     = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_HEIGHT = 3'd4,
        REG_LAYER  = 3'd5
    } t_reg_idx;

    // Result flags, lowest bit first in emission order:
    // bit 0 cell (row_a, col_a), bit 1 (row_a, col_b),
    // bit 2 (row_b, col_a), bit 3 (row_b, col_b).
    typedef struct packed {
        logic [8:0][DATA_W-1:0] win;
        logic [3:0]             flags;
        logic                   int_en;
        logic [COORD_W-1:0]     row_a;
        logic [COORD_W-1:0]     row_b;
        logic [COORD_W-1:0]     col_a;
        logic [COORD_W-1:0]     col_b;
    } t_job;

    typedef struct packed {
        logic [3:0]                flags;
        logic                      int_en;
        logic [COORD_W-1:0]        row_a;
        logic [COORD_W-1:0]        row_b;
        logic [COORD_W-1:0]        col_a;
        logic [COORD_W-1:0]        col_b;
        logic signed [DATA_W-1:0]  ctr;
        logic signed [DATA_W-1:0]  w5;
        logic signed [DATA_W-1:0]  w7;
        logic signed [DATA_W-1:0]  w8;
    } t_tag;

endpackage

// File: design/diffusion_stencil_3x3_step_core.sv
// Top level of the 3x3 diffusion stencil core: configuration registers,
// front end, job queue and arithmetic back end.
// Depends on dsts_pkg, dsts_front, dsts_queue and dsts_back.
//
// One explicit Euler diffusion step with decay over a region streamed in
// raster order. A row streams at one word per clock while full is low;
// the front end reads both line stores once per word through their single
// read port. Results leave at most one word per clock: an input on the
// bottom row or right column emits up to four words, and input stalls
// while the job queue (four jobs) fills behind them. An accepted word's
// first result passes through the line store read, the job queue and the
// six-stage multiply pipeline. Regions must be at least two rows and two
// columns; sizes are clamped into range. The line stores are not cleared
// after reset, and writing the region width or height restarts the region
// at row zero, column zero.
module diffusion_stencil_3x3_step_core import dsts_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready,
    input  logic                      push,
    output logic                      full,
    input  logic signed [DATA_W-1:0]  i_conc_in,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [DATA_W-1:0]  o_conc_out,
    output logic [COORD_W-1:0]        o_out_row,
    output logic [COORD_W-1:0]        o_out_col,
    output logic [LAYER_W-1:0]        o_layer,
    output logic                      o_last
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [COEF_W-1:0]     r_diffusion_rate;
    logic [COEF_W-1:0]     r_degradation_rate;
    logic [COEF_W-1:0]     r_time_step;
    logic [CFG_SIZE_W-1:0] r_region_width;
    logic [CFG_SIZE_W-1:0] r_region_height;
    logic [LAYER_W-1:0]    r_layer_tag;

    logic                  cfg_wr;
    t_reg_idx              cfg_idx;
    logic                  restart;
    logic [WW-1:0]         w_eff;
    logic [HW-1:0]         h_eff;

    logic                  job_push;
    t_job                  job_in;
    t_job                  job_out;
    logic                  job_valid;
    logic                  job_pop;
    logic [QCW-1:0]        q_count;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign restart = cfg_wr && ((cfg_idx == REG_WIDTH) || (cfg_idx == REG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diffusion_rate   <= '0;
            r_degradation_rate <= '0;
            r_time_step        <= '0;
            r_region_width     <= SIZE_RST;
            r_region_height    <= SIZE_RST;
            r_layer_tag        <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DIFF:   r_diffusion_rate   <= pwdata[COEF_W-1:0];
                REG_DEG:    r_degradation_rate <= pwdata[COEF_W-1:0];
                REG_DT:     r_time_step        <= pwdata[COEF_W-1:0];
                REG_WIDTH:  r_region_width     <= pwdata[CFG_SIZE_W-1:0];
                REG_HEIGHT: r_region_height    <= pwdata[CFG_SIZE_W-1:0];
                REG_LAYER:  r_layer_tag        <= pwdata[LAYER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_DIFF:   prdata = APB_DATA_W'(r_diffusion_rate);
            REG_DEG:    prdata = APB_DATA_W'(r_degradation_rate);
            REG_DT:     prdata = APB_DATA_W'(r_time_step);
            REG_WIDTH:  prdata = APB_DATA_W'(r_region_width);
            REG_HEIGHT: prdata = APB_DATA_W'(r_region_height);
            REG_LAYER:  prdata = APB_DATA_W'(r_layer_tag);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        if (r_region_width < CFG_SIZE_W'(2)) begin
            w_eff = WW'(2);
        end else if (32'(r_region_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_region_width);
        end
        if (r_region_height < CFG_SIZE_W'(2)) begin
            h_eff = HW'(2);
        end else if (32'(r_region_height) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_region_height);
        end
    end

    dsts_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_conc_in  (i_conc_in),
        .i_width    (w_eff),
        .i_height   (h_eff),
        .i_restart  (restart),
        .i_q_count  (q_count),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    dsts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_valid (job_valid),
        .o_count (q_count)
    );

    dsts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kdiff     (r_diffusion_rate),
        .i_kdeg      (r_degradation_rate),
        .i_dt        (r_time_step),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_conc_out  (o_conc_out),
        .o_row       (o_out_row),
        .o_col       (o_out_col),
        .o_last      (o_last)
    );

    assign o_layer = r_layer_tag;

endmodule

// File: design/dsts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module dsts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/dsts_front.sv
// Front end: accepts concentration words, keeps the raster position, the two
// line stores and the 3x3 window, and queues a job for every input that emits.
// Depends on dsts_pkg, dsts_ram and the assertion macro header.
`include "diffusion_stencil_3x3_step_core_defines.svh"
module dsts_front import dsts_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic [DATA_W-1:0]                  i_conc_in,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]   i_width,
    input  logic [$clog2(MAX_HEIGHT + 1)-1:0]  i_height,
    input  logic                               i_restart,
    input  logic [QCW-1:0]                     i_q_count,
    output logic                               o_job_push,
    output t_job                               o_job
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic          wrap;
    logic          col_last;
    logic          row_last;
    logic          accept;

    logic                   r_f1_valid;
    logic [DATA_W-1:0]      r_f1_x;
    logic [CW-1:0]          r_f1_col;
    logic [3:0]             r_f1_flags;
    logic                   r_f1_int;
    logic [COORD_W-1:0]     r_f1_row_a;
    logic [COORD_W-1:0]     r_f1_row_b;
    logic [COORD_W-1:0]     r_f1_col_a;
    logic [COORD_W-1:0]     r_f1_col_b;

    logic [8:0][DATA_W-1:0] r_win;
    logic [8:0][DATA_W-1:0] n_win;
    logic [DATA_W-1:0]      up1;
    logic [DATA_W-1:0]      up2;

    always_comb begin
        wrap     = (WW'(r_col) >= i_width) || (HW'(r_row) >= i_height);
        col_cur  = wrap ? '0 : r_col;
        row_cur  = wrap ? '0 : r_row;
        col_last = (WW'(col_cur) == (i_width - WW'(1)));
        row_last = (HW'(row_cur) == (i_height - HW'(1)));
        o_full   = (i_q_count == QCW'(Q_DEPTH)) ||
                   (r_f1_valid && (i_q_count == QCW'(Q_DEPTH - 1)));
        accept   = i_push && !o_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= accept;
            if (i_restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : row_cur + RW'(1);
                end else begin
                    r_col <= col_cur + CW'(1);
                    r_row <= row_cur;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_x        <= i_conc_in;
            r_f1_col      <= col_cur;
            r_f1_flags[0] <= (row_cur != '0) && (col_cur != '0);
            r_f1_flags[1] <= (row_cur != '0) && col_last;
            r_f1_flags[2] <= row_last && (col_cur != '0);
            r_f1_flags[3] <= row_last && col_last;
            r_f1_int      <= (row_cur > RW'(1)) && (col_cur > CW'(1));
            r_f1_row_a    <= COORD_W'(row_cur - RW'(1));
            r_f1_row_b    <= COORD_W'(row_cur);
            r_f1_col_a    <= COORD_W'(col_cur - CW'(1));
            r_f1_col_b    <= COORD_W'(col_cur);
        end
        if (r_f1_valid) begin
            r_win <= n_win;
        end
    end

    // Line store A holds the row above, line store B the row two above.
    dsts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .i_clk   (i_clk),
        .i_we    (r_f1_valid),
        .i_waddr (r_f1_col),
        .i_wdata (r_f1_x),
        .i_re    (accept),
        .i_raddr (col_cur),
        .o_rdata (up1)
    );

    dsts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .i_clk   (i_clk),
        .i_we    (r_f1_valid),
        .i_waddr (r_f1_col),
        .i_wdata (up1),
        .i_re    (accept),
        .i_raddr (col_cur),
        .o_rdata (up2)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[3*i]     = r_win[3*i+1];
            n_win[3*i + 1] = r_win[3*i+2];
        end
        n_win[2] = up2;
        n_win[5] = up1;
        n_win[8] = r_f1_x;

        o_job.win    = n_win;
        o_job.flags  = r_f1_flags;
        o_job.int_en = r_f1_int;
        o_job.row_a  = r_f1_row_a;
        o_job.row_b  = r_f1_row_b;
        o_job.col_a  = r_f1_col_a;
        o_job.col_b  = r_f1_col_b;
        o_job_push   = r_f1_valid && (r_f1_flags != 4'b0000);
    end

    `DSTS_ASSERT(a_col_in_range, i_clk, i_rst_n, (WW'(r_col) < i_width))

endmodule

// File: design/dsts_queue.sv
// Short job queue between the front end and the arithmetic back end.
// Depends on dsts_pkg and the assertion macro header.
`include "diffusion_stencil_3x3_step_core_defines.svh"
module dsts_queue import dsts_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  t_job           i_data,
    input  logic           i_pop,
    output t_job           o_data,
    output logic           o_valid,
    output logic [QCW-1:0] o_count
);

    t_job           r_mem [Q_DEPTH];
    logic [QPW-1:0] r_wr_ptr;
    logic [QPW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

    `DSTS_ASSERT_NEVER(a_q_overflow, i_clk, i_rst_n, i_push && (r_count == QCW'(Q_DEPTH)))
    `DSTS_ASSERT_NEVER(a_q_underflow, i_clk, i_rst_n, i_pop && (r_count == '0))

endmodule

// File: design/dsts_back.sv
// Back end: pipelined fixed-point stencil update of one job, then emission
// of the job's result words one at a time, lowest flag first.
// Depends on dsts_pkg and the assertion macro header.
`include "diffusion_stencil_3x3_step_core_defines.svh"
module dsts_back import dsts_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [COEF_W-1:0]         i_kdiff,
    input  logic [COEF_W-1:0]         i_kdeg,
    input  logic [COEF_W-1:0]         i_dt,
    input  logic                      i_job_valid,
    input  t_job                      i_job,
    output logic                      o_job_pop,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic signed [DATA_W-1:0]  o_conc_out,
    output logic [COORD_W-1:0]        o_row,
    output logic [COORD_W-1:0]        o_col,
    output logic                      o_last
);

    localparam int NSTG = 6;

    logic [NSTG-1:0] r_v;
    t_tag            r_tag [NSTG];
    t_tag            n_tag0;
    logic            en;

    logic signed [SUM4_W-1:0] n_orth, n_diag, r_orth, r_diag;
    logic signed [S_W-1:0]    n_s, r_s;
    logic [PLO_W-1:0]         n_p_lo, r_p_lo;
    logic signed [PHI_W-1:0]  n_p_hi, r_p_hi;
    logic signed [PDEG_W-1:0] n_p_deg, r_p_deg;
    logic signed [T_W-1:0]    n_t;
    logic signed [CH_W-1:0]   n_ch, r_ch;
    logic [QLO_W-1:0]         n_q_lo, r_q_lo;
    logic signed [QHI_W-1:0]  n_q_hi, r_q_hi;
    logic signed [P_W-1:0]    n_p;
    logic signed [RND_W-1:0]  n_rnd, r_rnd;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [DATA_W-1:0] sat;
    logic signed [DATA_W-1:0] n_val0;

    logic [3:0]               r_em_flags;
    logic signed [DATA_W-1:0] r_em_val0;
    t_tag                     r_em_tag;

    always_comb begin
        en        = (r_em_flags == 4'b0000) ||
                    (i_pop && ((r_em_flags & (r_em_flags - 4'd1)) == 4'b0000));
        o_job_pop = en && i_job_valid;

        n_tag0.flags  = i_job.flags;
        n_tag0.int_en = i_job.int_en;
        n_tag0.row_a  = i_job.row_a;
        n_tag0.row_b  = i_job.row_b;
        n_tag0.col_a  = i_job.col_a;
        n_tag0.col_b  = i_job.col_b;
        n_tag0.ctr    = $signed(i_job.win[4]);
        n_tag0.w5     = $signed(i_job.win[5]);
        n_tag0.w7     = $signed(i_job.win[7]);
        n_tag0.w8     = $signed(i_job.win[8]);

        n_orth = SUM4_W'($signed(i_job.win[1])) + SUM4_W'($signed(i_job.win[3]))
               + SUM4_W'($signed(i_job.win[5])) + SUM4_W'($signed(i_job.win[7]));
        n_diag = SUM4_W'($signed(i_job.win[0])) + SUM4_W'($signed(i_job.win[2]))
               + SUM4_W'($signed(i_job.win[6])) + SUM4_W'($signed(i_job.win[8]));

        // Twice the stencil sum: orthogonal weight 2, diagonal 1, center -12.
        n_s = (S_W'(r_orth) <<< 1) + S_W'(r_diag)
            - (S_W'(r_tag[0].ctr) <<< 3) - (S_W'(r_tag[0].ctr) <<< 2);

        n_p_lo  = i_kdiff * r_s[S_LO_W-1:0];
        n_p_hi  = $signed({1'b0, i_kdiff}) * $signed(r_s[S_W-1:S_LO_W]);
        n_p_deg = $signed({1'b0, i_kdeg}) * r_tag[1].ctr;

        n_t  = (T_W'(r_p_hi) <<< S_LO_W) + T_W'($signed({1'b0, r_p_lo}))
             - (T_W'(r_p_deg) <<< 1) + T_W'(65536);
        n_ch = CH_W'(n_t >>> 17);

        n_q_lo = i_dt * r_ch[CH_LO_W-1:0];
        n_q_hi = $signed({1'b0, i_dt}) * $signed(r_ch[CH_W-1:CH_LO_W]);

        n_p   = (P_W'(r_q_hi) <<< CH_LO_W) + P_W'($signed({1'b0, r_q_lo})) + P_W'(32768);
        n_rnd = RND_W'(n_p >>> 16);

        n_sum = SUM_W'(r_rnd) + SUM_W'(r_tag[NSTG-1].ctr);
        if (n_sum > SUM_W'(SAT_MAX)) begin
            sat = SAT_MAX;
        end else if (n_sum < SUM_W'(SAT_MIN)) begin
            sat = SAT_MIN;
        end else begin
            sat = DATA_W'(n_sum);
        end
        n_val0 = r_tag[NSTG-1].int_en ? sat : r_tag[NSTG-1].ctr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v        <= '0;
            r_em_flags <= 4'b0000;
        end else if (en) begin
            r_v        <= {r_v[NSTG-2:0], i_job_valid};
            r_em_flags <= r_v[NSTG-1] ? r_tag[NSTG-1].flags : 4'b0000;
        end else if (i_pop) begin
            r_em_flags <= r_em_flags & (r_em_flags - 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[0] <= n_tag0;
            for (int k = 1; k < NSTG; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
            r_orth    <= n_orth;
            r_diag    <= n_diag;
            r_s       <= n_s;
            r_p_lo    <= n_p_lo;
            r_p_hi    <= n_p_hi;
            r_p_deg   <= n_p_deg;
            r_ch      <= n_ch;
            r_q_lo    <= n_q_lo;
            r_q_hi    <= n_q_hi;
            r_rnd     <= n_rnd;
            r_em_val0 <= n_val0;
            r_em_tag  <= r_tag[NSTG-1];
        end
    end

    always_comb begin
        o_empty = (r_em_flags == 4'b0000);
        o_last  = ((r_em_flags & (r_em_flags - 4'd1)) == 4'b0000);
        priority if (r_em_flags[0]) begin
            o_conc_out = r_em_val0;
            o_row      = r_em_tag.row_a;
            o_col      = r_em_tag.col_a;
        end else if (r_em_flags[1]) begin
            o_conc_out = r_em_tag.w5;
            o_row      = r_em_tag.row_a;
            o_col      = r_em_tag.col_b;
        end else if (r_em_flags[2]) begin
            o_conc_out = r_em_tag.w7;
            o_row      = r_em_tag.row_b;
            o_col      = r_em_tag.col_a;
        end else begin
            o_conc_out = r_em_tag.w8;
            o_row      = r_em_tag.row_b;
            o_col      = r_em_tag.col_b;
        end
    end

    `DSTS_ASSERT(a_emit_one_bit, i_clk, i_rst_n, (!o_empty && i_pop && !o_last) |=> ($countones(r_em_flags) == $past($countones(r_em_flags)) - 1))

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for diffusion_stencil_3x3_step_core: streams concentration words,
// predicts every updated site with its own stencil model and compares each popped word.
// Depends on dsts_pkg and the core RTL.
module tb;
    import dsts_pkg::*;

    localparam int MAX_SPAN   = 1024;
    localparam int DRAIN_WAIT = 24;
    localparam int LIMIT      = 600000;

    typedef struct {
        logic signed [DATA_W-1:0] conc;
        logic [COORD_W-1:0]       row;
        logic [COORD_W-1:0]       col;
        logic [LAYER_W-1:0]       layer;
        logic                     last_flag;
    } t_site_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0]    pwdata;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     push;
    logic                     full;
    logic signed [DATA_W-1:0] i_conc_in;
    logic                     empty;
    logic                     pop;
    logic signed [DATA_W-1:0] o_conc_out;
    logic [COORD_W-1:0]       o_out_row;
    logic [COORD_W-1:0]       o_out_col;
    logic [LAYER_W-1:0]       o_layer;
    logic                     o_last;

    diffusion_stencil_3x3_step_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .full       (full),
        .i_conc_in  (i_conc_in),
        .empty      (empty),
        .pop        (pop),
        .o_conc_out (o_conc_out),
        .o_out_row  (o_out_row),
        .o_out_col  (o_out_col),
        .o_layer    (o_layer),
        .o_last     (o_last)
    );

    always #4 i_clk = ~i_clk;

    logic [COEF_W-1:0]     k_diff;
    logic [COEF_W-1:0]     k_deg;
    logic [COEF_W-1:0]     dt_step;
    logic [CFG_SIZE_W-1:0] width_reg;
    logic [CFG_SIZE_W-1:0] height_reg;
    logic [LAYER_W-1:0]    layer_reg;
    logic [DATA_W-1:0]     row_above [MAX_SPAN];
    logic [DATA_W-1:0]     row_above2 [MAX_SPAN];
    logic [DATA_W-1:0]     win [9];
    int unsigned           next_row;
    int unsigned           next_col;

    t_site_result expected_sites [$];
    t_site_result want;

    int send_idle_pct;
    int pop_stall_pct;
    int hold_left;
    int error_count;
    int mismatch_count;
    int words_sent;
    int sites_checked;
    int cycle_count;

    function automatic int unsigned clamp_span(logic [CFG_SIZE_W-1:0] v);
        if (v < 2) return 2;
        if (v > MAX_SPAN) return MAX_SPAN;
        return 32'(v);
    endfunction

    function automatic logic signed [DATA_W-1:0] euler_update();
        longint ctr, s, t, change, hi, lo, dt, r;
        ctr = longint'($signed(win[4]));
        s = 2 * (longint'($signed(win[1])) + longint'($signed(win[3]))
               + longint'($signed(win[5])) + longint'($signed(win[7])))
            + longint'($signed(win[0])) + longint'($signed(win[2]))
            + longint'($signed(win[6])) + longint'($signed(win[8]))
            - 12 * ctr;
        t = longint'(k_diff) * s - 2 * longint'(k_deg) * ctr;
        change = (t + 65536) >>> 17;
        hi = change >>> 16;
        lo = change - hi * 65536;
        dt = longint'(dt_step);
        r = ctr + dt * hi + ((dt * lo + 32768) >>> 16);
        if (r > longint'(SAT_MAX)) return SAT_MAX;
        if (r < longint'(SAT_MIN)) return SAT_MIN;
        return r[DATA_W-1:0];
    endfunction

    function automatic void queue_site(logic signed [DATA_W-1:0] v, int unsigned r,
                                       int unsigned c, bit is_last);
        t_site_result s;
        s.conc      = v;
        s.row       = r[COORD_W-1:0];
        s.col       = c[COORD_W-1:0];
        s.layer     = layer_reg;
        s.last_flag = is_last;
        expected_sites.push_back(s);
    endfunction

    function automatic void advance_stencil(logic [DATA_W-1:0] x);
        int unsigned w, h, r, c;
        logic [DATA_W-1:0] up1, up2;
        bit e0, e1, e2, e3;
        w = clamp_span(width_reg);
        h = clamp_span(height_reg);
        if (next_col >= w || next_row >= h) begin
            next_row = 0;
            next_col = 0;
        end
        r = next_row;
        c = next_col;
        up1 = row_above[c];
        up2 = row_above2[c];
        for (int i = 0; i < 3; i++) begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = x;
        row_above2[c] = up1;
        row_above[c]  = x;

        e0 = (r >= 1 && c >= 1);
        e1 = (r >= 1 && c == w - 1);
        e2 = (r == h - 1 && c >= 1);
        e3 = (r == h - 1 && c == w - 1);
        if (e0)
            queue_site((r >= 2 && c >= 2) ? euler_update() : $signed(win[4]), r - 1, c - 1,
                       !(e1 || e2 || e3));
        if (e1)
            queue_site($signed(win[5]), r - 1, w - 1, !(e2 || e3));
        if (e2)
            queue_site($signed(win[7]), h - 1, c - 1, !e3);
        if (e3)
            queue_site($signed(win[8]), h - 1, w - 1, 1'b1);

        next_col = c + 1;
        if (next_col >= w) begin
            next_col = 0;
            next_row = r + 1;
            if (next_row >= h) next_row = 0;
        end
    endfunction

    function automatic void apply_reg(t_reg_idx idx, logic [APB_DATA_W-1:0] v);
        case (idx)
            REG_DIFF: k_diff = v[COEF_W-1:0];
            REG_DEG: k_deg = v[COEF_W-1:0];
            REG_DT: dt_step = v[COEF_W-1:0];
            REG_WIDTH: begin
                width_reg = v[CFG_SIZE_W-1:0];
                next_row = 0;
                next_col = 0;
            end
            REG_HEIGHT: begin
                height_reg = v[CFG_SIZE_W-1:0];
                next_row = 0;
                next_col = 0;
            end
            REG_LAYER: layer_reg = v[LAYER_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_conc();
        case ($urandom_range(9))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2, 3: return $urandom;
            default: return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [APB_DATA_W-1:0] random_coef();
        case ($urandom_range(3))
            0: return 0;
            1: return $urandom_range(0, 32'h00FF_FFFF);
            default: return $urandom_range(0, 32'h0001_FFFF);
        endcase
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(logic [APB_DATA_W-1:0] kd, logic [APB_DATA_W-1:0] kg,
                             logic [APB_DATA_W-1:0] dt, logic [APB_DATA_W-1:0] w,
                             logic [APB_DATA_W-1:0] h, logic [APB_DATA_W-1:0] layer);
        write_reg(REG_DIFF, kd);
        write_reg(REG_DEG, kg);
        write_reg(REG_DT, dt);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_LAYER, layer);
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        send_idle_pct = sender_pct;
        pop_stall_pct = receiver_pct;
    endtask

    task automatic send_word(logic [DATA_W-1:0] x);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push      = 1'b1;
        i_conc_in = x;
        do @(posedge i_clk); while (full);
        advance_stencil(x);
        words_sent++;
    endtask

    task automatic send_region(int w, int h);
        for (int i = 0; i < w * h; i++) send_word(random_conc());
    endtask

    task automatic finish_burst();
        @(negedge i_clk);
        push = 1'b0;
        while (expected_sites.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Receiver side: random stalls, or a long hold-off while hold_left runs down.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop = 1'b0;
        end else if (hold_left > 0) begin
            pop = 1'b0;
            hold_left--;
        end else begin
            pop = ($urandom_range(99) >= pop_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sites_checked++;
            if (expected_sites.size() == 0) begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected word: conc %h row %0d col %0d layer %0d last %b",
                             o_conc_out, o_out_row, o_out_col, o_layer, o_last);
            end else begin
                want = expected_sites.pop_front();
                if (o_conc_out !== want.conc || o_out_row !== want.row
                        || o_out_col !== want.col || o_layer !== want.layer
                        || o_last !== want.last_flag) begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch: expected conc %h row %0d col %0d layer %0d last %b",
                                 want.conc, want.row, want.col, want.layer, want.last_flag);
                        $display("          got      conc %h row %0d col %0d layer %0d last %b",
                                 o_conc_out, o_out_row, o_out_col, o_layer, o_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("Timeout after %0d cycles with %0d words outstanding",
                     cycle_count, expected_sites.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_saturation();
        set_idling(0, 0);
        configure(32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 3, 3, 255);
        for (int i = 0; i < 9; i++) send_word((i == 4) ? SAT_MIN : SAT_MAX);
        finish_burst();
        write_reg(REG_LAYER, 0);
        for (int i = 0; i < 9; i++) send_word((i == 4) ? SAT_MAX : SAT_MIN);
        finish_burst();
    endtask

    task automatic test_clamped_small_region();
        set_idling(0, 0);
        configure(random_coef(), random_coef(), random_coef(), 0, 1, 8'hA5);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);
        send_word(32'h0000_0001);
        send_word(SAT_MIN);
        finish_burst();
    endtask

    task automatic test_region_restart();
        set_idling(0, 0);
        configure(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 3, 3, 8'h5A);
        send_region(1, 5);
        finish_burst();
        write_reg(REG_WIDTH, 3);
        send_region(3, 3);
        send_region(1, 4);
        finish_burst();
        write_reg(REG_HEIGHT, 3);
        send_region(3, 3);
        finish_burst();
    endtask

    task automatic test_random_phases();
        int w, h;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_idling(0, 0);
                1: set_idling(53, 0);
                2: set_idling(0, 53);
                default: set_idling(27, 27);
            endcase
            w = $urandom_range(2, 4);
            h = $urandom_range(2, 4);
            configure(random_coef(), random_coef(), random_coef(), w, h, $urandom_range(255));
            send_region(w, h);
            if (ph % 2 == 1) send_region(1, $urandom_range(1, w));
            finish_burst();
        end
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        configure(random_coef(), random_coef(), random_coef(), 5, 4, $urandom_range(255));
        hold_left = 300;
        send_region(5, 4);
        finish_burst();
    endtask

    initial begin
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        push      = 1'b0;
        pop       = 1'b0;
        i_conc_in = '0;
        k_diff    = '0;
        k_deg     = '0;
        dt_step   = '0;
        width_reg = SIZE_RST;
        height_reg = SIZE_RST;
        layer_reg = '0;
        next_row  = 0;
        next_col  = 0;
        for (int i = 0; i < MAX_SPAN; i++) begin
            row_above[i]  = '0;
            row_above2[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        send_idle_pct  = 0;
        pop_stall_pct  = 0;
        hold_left      = 0;
        error_count    = 0;
        mismatch_count = 0;
        words_sent     = 0;
        sites_checked  = 0;
        cycle_count    = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_saturation();
        test_clamped_small_region();
        test_region_restart();
        test_random_phases();
        test_backpressure();

        finish_burst();
        if (expected_sites.size() != 0) begin
            error_count++;
            $display("%0d expected words never arrived", expected_sites.size());
        end
        $display("Sent %0d words and checked %0d results over saturating, clamped, restarted,",
                 words_sent, sites_checked);
        $display("randomly idled and back-pressured regions; %0d errors.", error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
